// ===== hw/rtl/dynamic_partition_allocator_core_defines.svh =====
// Assertion macros for the partition allocator checker.
// Included by the checker file only; no dependencies.
`ifndef DYNAMIC_PARTITION_ALLOCATOR_CORE_DEFINES_SVH
`define DYNAMIC_PARTITION_ALLOCATOR_CORE_DEFINES_SVH
// Implication checked every edge outside reset.
`define DPA_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("dpa check failed");
// Next-cycle implication.
`define DPA_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("dpa check failed");
`endif

// ===== hw/rtl/dpa_pkg.sv =====
// Shared types and codes for the partition allocator.
// No dependencies.
`timescale 1ns / 1ps
package dpa_pkg;
  localparam logic [1:0] REQ_INIT = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE = 2'd2;
  localparam logic [1:0] REQ_COMPACT = 2'd3;
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT = 2'd3;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_FIT = 3'd2;
  localparam logic [2:0] ST_BAD_ID = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;
  localparam logic [31:0] DEFAULT_MEMORY = 32'd1048576;
  localparam logic CFG_FIT_MODE = 1'b0;
  localparam logic CFG_MEMORY_SIZE = 1'b1;
  // Datapath operations.
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_INIT = 4'd1;
  localparam logic [3:0] OP_SCAN_RST = 4'd2;
  localparam logic [3:0] OP_SCAN = 4'd3;
  localparam logic [3:0] OP_SHIFT_UP = 4'd4;
  localparam logic [3:0] OP_SPLIT = 4'd5;
  localparam logic [3:0] OP_GRANT = 4'd6;
  localparam logic [3:0] OP_RELEASE = 4'd7;
  localparam logic [3:0] OP_MERGE = 4'd8;
  localparam logic [3:0] OP_REMOVE = 4'd9;
  localparam logic [3:0] OP_COMP_STEP = 4'd10;
  localparam logic [3:0] OP_COMP_TAIL = 4'd11;
  localparam logic [3:0] OP_COMP_CLR = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic       scan_free; // scan looks for an owner instead of a fit
    logic       merge_left; // merge target is index-1 instead of index+1
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic exact;
    logic table_full;
    logic ids_out;
    logic shift_done;
    logic right_free;
    logic left_free;
    logic comp_done;
    logic clr_done;
  } stat_t;
endpackage

// ===== hw/rtl/dpa_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface dpa_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/dynamic_partition_allocator_core.sv =====
// Top level of the variable-partition allocator: channels, config, core.
// Depends on dpa_pkg, dpa_if, dpa_ctrl and dpa_datapath.
//
//  channel | dir | payload
//  req     | in  | req_type[1:0], req_size[31:0], free_id[ID_BITS-1:0]
//  rsp     | out | status[2:0], granted_id[ID_BITS-1:0], granted_start[31:0]
//  cfg     | in  | index[0] (0 fit_mode, 1 memory_size), wdata[31:0]
//
// A request word is shortest for init, bad size or bad id, and longest for a
// free near the head of a full table that merges on both sides (the owner
// scan, then two pull-down passes); the fit scan, the table shifts and
// compaction each walk one entry per cycle.
// Reset is synchronous; it restores the table to one free partition.
// A stalled response word is held; the next request is taken once the
// response register is free.
`timescale 1ns / 1ps
module dynamic_partition_allocator_core #(
  parameter int MAX_PARTS = 32,
  parameter int ID_BITS = 16
) (
  input logic clk,
  input logic rst,
  dpa_if.sink   req,
  dpa_if.source rsp,
  dpa_if.sink   cfg
);
  logic [1:0]  fit_mode;
  logic [31:0] memory_size;

  // Latch the request word for the whole operation.
  logic [1:0]         r_type;
  logic [31:0]        r_size;
  logic [ID_BITS-1:0] r_id;

  logic busy, done, start, rsp_valid;
  logic [2:0] status;
  dpa_pkg::cmd_t  cmd;
  dpa_pkg::stat_t stat;
  logic [ID_BITS-1:0] gid;
  logic [31:0]        gstart;
  logic [2:0]         o_status;
  logic [ID_BITS-1:0] o_id;
  logic [31:0]        o_start;
  logic               pend;

  // Accept one request at a time; wait for the response slot to drain.
  assign req.ready = !pend && !busy && !rsp_valid;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      start <= 1'b0;
    end else begin
      start <= req.valid && req.ready;
      if (req.valid && req.ready) pend <= 1'b1;
      else if (done) pend <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      r_type <= req.data[1:0];
      r_size <= req.data[33:2];
      r_id <= req.data[34 +: ID_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= dpa_pkg::FIT_FIRST;
      memory_size <= dpa_pkg::DEFAULT_MEMORY;
    end else if (cfg.valid) begin
      if (cfg.data[32] == dpa_pkg::CFG_FIT_MODE) fit_mode <= cfg.data[1:0];
      else memory_size <= cfg.data[31:0];
    end
  end

  dpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req_type(r_type),
    .size_zero(r_size == '0), .id_zero(r_id == '0), .stat(stat),
    .cmd(cmd), .busy(busy), .done(done), .status(status)
  );

  dpa_datapath #(.MAX_PARTS(MAX_PARTS), .ID_BITS(ID_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .fit_mode(fit_mode),
    .memory_size(memory_size), .req_size(r_size), .free_id(r_id),
    .stat(stat), .grant_id(gid), .grant_start(gstart)
  );

  // Response register; ids and start show only for a good allocation.
  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (done) rsp_valid <= 1'b1;
    else if (rsp.ready) rsp_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (done) begin
      o_status <= status;
      o_id <= (r_type == dpa_pkg::REQ_ALLOC && status == dpa_pkg::ST_OK) ? gid : '0;
      o_start <= (r_type == dpa_pkg::REQ_ALLOC && status == dpa_pkg::ST_OK) ?
                 gstart : '0;
    end
  end
  assign rsp.valid = rsp_valid;
  assign rsp.data = {o_start, o_id, o_status};
endmodule

// ===== hw/rtl/dpa_ctrl.sv =====
// Request sequencer for the partition allocator.
// Depends on dpa_pkg.
`timescale 1ns / 1ps
module dpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         req_type,
  input  logic               size_zero,
  input  logic               id_zero,
  input  dpa_pkg::stat_t     stat,
  output dpa_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               done,
  output logic [2:0]         status
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_SPLIT = 4'd4;
  localparam logic [3:0] S_FSCAN = 4'd5;
  localparam logic [3:0] S_MR = 4'd6;
  localparam logic [3:0] S_RMR = 4'd7;
  localparam logic [3:0] S_ML = 4'd8;
  localparam logic [3:0] S_RML = 4'd9;
  localparam logic [3:0] S_COMP = 4'd10;
  localparam logic [3:0] S_CLR = 4'd11;
  localparam logic [3:0] S_FIN = 4'd12;
  localparam logic [3:0] S_FCHK = 4'd13;

  logic [3:0] state, state_next;
  logic [2:0] st_reg, st_next;

  assign busy = (state != S_IDLE);
  assign status = st_reg;

  always_comb begin
    state_next = state;
    st_next = st_reg;
    cmd = '0;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          st_next = dpa_pkg::ST_OK;
          case (req_type)
            dpa_pkg::REQ_INIT: begin
              cmd.op = dpa_pkg::OP_INIT;
              state_next = S_FIN;
            end
            dpa_pkg::REQ_ALLOC: begin
              if (size_zero) begin
                st_next = dpa_pkg::ST_BAD_SIZE;
                state_next = S_FIN;
              end else begin
                cmd.op = dpa_pkg::OP_SCAN_RST;
                state_next = S_SCAN;
              end
            end
            dpa_pkg::REQ_FREE: begin
              if (id_zero) begin
                st_next = dpa_pkg::ST_BAD_ID;
                state_next = S_FIN;
              end else begin
                cmd.op = dpa_pkg::OP_SCAN_RST;
                cmd.scan_free = 1'b1;
                state_next = S_FSCAN;
              end
            end
            default: begin
              cmd.op = dpa_pkg::OP_SCAN_RST;
              state_next = S_COMP;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.op = dpa_pkg::OP_SCAN;
        if (stat.scan_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.found) begin
          st_next = dpa_pkg::ST_NO_FIT;
          state_next = S_FIN;
        end else if (stat.ids_out || (!stat.exact && stat.table_full)) begin
          st_next = dpa_pkg::ST_FULL;
          state_next = S_FIN;
        end else if (stat.exact) begin
          cmd.op = dpa_pkg::OP_GRANT;
          state_next = S_FIN;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          cmd.op = dpa_pkg::OP_SPLIT;
          state_next = S_SPLIT;
        end else begin
          cmd.op = dpa_pkg::OP_SHIFT_UP;
        end
      end
      S_SPLIT: begin
        cmd.op = dpa_pkg::OP_GRANT;
        state_next = S_FIN;
      end
      S_FSCAN: begin
        cmd.op = dpa_pkg::OP_SCAN;
        cmd.scan_free = 1'b1;
        if (stat.scan_done) state_next = S_FCHK;
      end
      S_FCHK: begin
        if (!stat.found) begin
          st_next = dpa_pkg::ST_NOT_FOUND;
          state_next = S_FIN;
        end else begin
          cmd.op = dpa_pkg::OP_RELEASE;
          state_next = S_MR;
        end
      end
      S_MR: begin
        if (stat.right_free) begin
          cmd.op = dpa_pkg::OP_MERGE;
          state_next = S_RMR;
        end else begin
          state_next = S_ML;
        end
      end
      S_RMR: begin
        if (stat.shift_done) state_next = S_ML;
        else cmd.op = dpa_pkg::OP_REMOVE;
      end
      S_ML: begin
        if (stat.left_free) begin
          cmd.op = dpa_pkg::OP_MERGE;
          cmd.merge_left = 1'b1;
          state_next = S_RML;
        end else begin
          state_next = S_FIN;
        end
      end
      S_RML: begin
        if (stat.shift_done) state_next = S_FIN;
        else cmd.op = dpa_pkg::OP_REMOVE;
      end
      S_COMP: begin
        if (stat.comp_done) begin
          cmd.op = dpa_pkg::OP_COMP_TAIL;
          state_next = S_CLR;
        end else begin
          cmd.op = dpa_pkg::OP_COMP_STEP;
        end
      end
      S_CLR: begin
        if (stat.clr_done) state_next = S_FIN;
        else cmd.op = dpa_pkg::OP_COMP_CLR;
      end
      S_FIN: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st_reg <= dpa_pkg::ST_OK;
    end else begin
      state <= state_next;
      st_reg <= st_next;
    end
  end
endmodule

// ===== hw/rtl/dpa_datapath.sv =====
// Partition table, scan pointer and arithmetic for the allocator.
// Depends on dpa_pkg.
`timescale 1ns / 1ps
module dpa_datapath #(
  parameter int MAX_PARTS = 32,
  parameter int ID_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dpa_pkg::cmd_t      cmd,
  input  logic [1:0]         fit_mode,
  input  logic [31:0]        memory_size,
  input  logic [31:0]        req_size,
  input  logic [ID_BITS-1:0] free_id,
  output dpa_pkg::stat_t     stat,
  output logic [ID_BITS-1:0] grant_id,
  output logic [31:0]        grant_start
);
  localparam int IW = $clog2(MAX_PARTS);
  localparam int CW = $clog2(MAX_PARTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_PARTS);

  // Table in flip-flops: shifts move one entry per cycle.
  logic [31:0]        p_start [MAX_PARTS];
  logic [31:0]        p_size  [MAX_PARTS];
  logic               p_used  [MAX_PARTS];
  logic [ID_BITS-1:0] p_owner [MAX_PARTS];
  logic [CW-1:0]      count;
  logic [ID_BITS:0]   id_ctr;
  logic [IW-1:0]      rover;

  // Scan state.
  logic [CW-1:0] ptr;      // pointer/steps taken
  logic [CW-1:0] src;      // compaction read index
  logic          found;
  logic [IW-1:0] pick;
  logic [32:0]   curr;     // compaction running address
  logic [CW-1:0] shcnt;    // shift cursor

  logic [31:0] eff_mem;
  assign eff_mem = (memory_size == '0) ? dpa_pkg::DEFAULT_MEMORY : memory_size;

  // Scan index: next fit starts at the rover and wraps.
  logic [CW-1:0] sbase, sidx_w;
  logic [IW-1:0] sidx;
  logic          scan_end;
  always_comb begin
    sbase = (fit_mode == dpa_pkg::FIT_NEXT && !cmd.scan_free &&
             CW'(rover) < count) ? CW'(rover) : '0;
    sidx_w = sbase + ptr;
    if (sidx_w >= count) sidx_w = sidx_w - count;
    sidx = sidx_w[IW-1:0];
  end
  assign scan_end = (ptr >= count) ||
    (found && (cmd.scan_free || fit_mode == dpa_pkg::FIT_FIRST ||
               fit_mode == dpa_pkg::FIT_NEXT));

  logic hit;
  always_comb begin
    if (cmd.scan_free)
      hit = p_used[sidx] && (p_owner[sidx] == free_id);
    else
      hit = !p_used[sidx] && (p_size[sidx] >= req_size) &&
            (!found ||
             (fit_mode == dpa_pkg::FIT_BEST && p_size[sidx] < p_size[pick]) ||
             (fit_mode == dpa_pkg::FIT_WORST && p_size[sidx] > p_size[pick]));
  end

  logic [IW-1:0] pk1, pkm1, rmv;
  assign pk1 = pick + IW'(1);
  assign pkm1 = pick - IW'(1);

  always_comb begin
    stat = '0;
    stat.scan_done = scan_end;
    stat.found = found;
    stat.exact = (p_size[pick] == req_size);
    stat.table_full = (count >= MAXC);
    stat.ids_out = id_ctr[ID_BITS];
    stat.shift_done = cmd.op == dpa_pkg::OP_NONE ? (shcnt == '0) : (shcnt == '0);
    stat.right_free = (CW'(pk1) < count) && (CW'(pick) + 1'b1 < CW'(count)) &&
                      !p_used[pk1];
    stat.left_free = (pick != '0) && !p_used[pkm1];
    stat.comp_done = (src >= count);
    stat.clr_done = (ptr >= MAXC);
  end

  assign rmv = shcnt[IW-1:0];
  logic [32:0] asum;
  assign asum = {1'b0, p_start[pick]} + {1'b0, req_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PARTS; i++) begin
        p_start[i] <= '0;
        p_size[i] <= '0;
        p_used[i] <= 1'b0;
        p_owner[i] <= '0;
      end
      p_size[0] <= dpa_pkg::DEFAULT_MEMORY;
      count <= CW'(1);
      id_ctr <= (ID_BITS+1)'(1);
      rover <= '0;
      ptr <= '0;
      src <= '0;
      found <= 1'b0;
      pick <= '0;
      curr <= '0;
      shcnt <= '0;
    end else begin
      case (cmd.op)
        dpa_pkg::OP_INIT: begin
          for (int i = 0; i < MAX_PARTS; i++) begin
            p_start[i] <= '0;
            p_size[i] <= '0;
            p_used[i] <= 1'b0;
            p_owner[i] <= '0;
          end
          p_size[0] <= eff_mem;
          count <= CW'(1);
          id_ctr <= (ID_BITS+1)'(1);
          rover <= '0;
        end
        dpa_pkg::OP_SCAN_RST: begin
          ptr <= '0;
          src <= '0;
          found <= 1'b0;
          pick <= '0;
          curr <= '0;
          shcnt <= count; // used by alloc shift: k runs count down to pick+2
        end
        dpa_pkg::OP_SCAN: begin
          if (!scan_end) begin
            ptr <= ptr + 1'b1;
            if (hit) begin
              found <= 1'b1;
              pick <= sidx;
            end
          end
          shcnt <= count;
        end
        dpa_pkg::OP_SHIFT_UP: begin
          // move entry k-1 into k, k from count down to pick+2
          if (shcnt > CW'(pick) + CW'(1)) begin
            p_start[shcnt[IW-1:0]] <= p_start[shcnt[IW-1:0] - IW'(1)];
            p_size[shcnt[IW-1:0]] <= p_size[shcnt[IW-1:0] - IW'(1)];
            p_used[shcnt[IW-1:0]] <= p_used[shcnt[IW-1:0] - IW'(1)];
            p_owner[shcnt[IW-1:0]] <= p_owner[shcnt[IW-1:0] - IW'(1)];
            shcnt <= shcnt - 1'b1;
          end else begin
            shcnt <= '0;
          end
        end
        dpa_pkg::OP_SPLIT: begin
          p_start[pk1] <= asum[31:0];
          p_size[pk1] <= p_size[pick] - req_size;
          p_used[pk1] <= 1'b0;
          p_owner[pk1] <= '0;
          p_size[pick] <= req_size;
          count <= count + 1'b1;
          if (rover > pick) rover <= rover + IW'(1);
        end
        dpa_pkg::OP_GRANT: begin
          p_used[pick] <= 1'b1;
          p_owner[pick] <= id_ctr[ID_BITS-1:0];
          if (fit_mode == dpa_pkg::FIT_NEXT) rover <= pick;
          grant_id <= id_ctr[ID_BITS-1:0];
          grant_start <= p_start[pick];
          id_ctr <= id_ctr + 1'b1;
        end
        dpa_pkg::OP_RELEASE: begin
          p_used[pick] <= 1'b0;
          p_owner[pick] <= '0;
        end
        dpa_pkg::OP_MERGE: begin
          // shcnt becomes the removed index j; entries j..count-2 pull down
          if (cmd.merge_left) begin
            p_size[pkm1] <= p_size[pkm1] + p_size[pick];
            shcnt <= CW'(pick);
            if (rover >= pick && rover != '0) rover <= rover - IW'(1);
            pick <= pkm1;
          end else begin
            p_size[pick] <= p_size[pick] + p_size[pk1];
            shcnt <= CW'(pk1);
            if (rover >= pk1 && rover != '0) rover <= rover - IW'(1);
          end
        end
        dpa_pkg::OP_REMOVE: begin
          if (shcnt + 1'b1 < count) begin
            p_start[rmv] <= p_start[rmv + IW'(1)];
            p_size[rmv] <= p_size[rmv + IW'(1)];
            p_used[rmv] <= p_used[rmv + IW'(1)];
            p_owner[rmv] <= p_owner[rmv + IW'(1)];
            shcnt <= shcnt + 1'b1;
          end else begin
            count <= count - 1'b1;
            shcnt <= '0;
          end
        end
        dpa_pkg::OP_COMP_STEP: begin
          if (p_used[src[IW-1:0]]) begin
            p_size[ptr[IW-1:0]] <= p_size[src[IW-1:0]];
            p_owner[ptr[IW-1:0]] <= p_owner[src[IW-1:0]];
            p_used[ptr[IW-1:0]] <= 1'b1;
            p_start[ptr[IW-1:0]] <= curr[31:0];
            curr <= curr + {1'b0, p_size[src[IW-1:0]]};
            ptr <= ptr + 1'b1;
          end
          src <= src + 1'b1;
        end
        dpa_pkg::OP_COMP_TAIL: begin
          if (curr < {1'b0, eff_mem} && ptr < MAXC) begin
            p_start[ptr[IW-1:0]] <= curr[31:0];
            p_size[ptr[IW-1:0]] <= eff_mem - curr[31:0];
            p_used[ptr[IW-1:0]] <= 1'b0;
            p_owner[ptr[IW-1:0]] <= '0;
            ptr <= ptr + 1'b1;
            count <= ptr + 1'b1;
          end else begin
            count <= ptr;
          end
          rover <= '0;
        end
        dpa_pkg::OP_COMP_CLR: begin
          p_start[ptr[IW-1:0]] <= '0;
          p_size[ptr[IW-1:0]] <= '0;
          p_used[ptr[IW-1:0]] <= 1'b0;
          p_owner[ptr[IW-1:0]] <= '0;
          ptr <= ptr + 1'b1;
        end
        default: ;
      endcase
      if (cmd.op == dpa_pkg::OP_SCAN_RST) begin
        grant_id <= '0;
        grant_start <= '0;
      end
    end
  end
endmodule

// ===== hw/rtl/dpa_checker.sv =====
// Port-level checks for the allocator top level, bound in below.
// Depends on dynamic_partition_allocator_core_defines.svh.
`timescale 1ns / 1ps
`include "dynamic_partition_allocator_core_defines.svh"
module dpa_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [2:0] rsp_status
);
  `DPA_ASSERT_IMP(a_status_range, clk, rst, rsp_valid, rsp_status <= 3'd5)
  `DPA_ASSERT_NXT(a_no_take_after_take, clk, rst, req_valid && req_ready, !req_ready)
  `DPA_ASSERT_IMP(a_no_take_while_rsp, clk, rst, rsp_valid, !req_ready)
  `DPA_ASSERT_NXT(a_rsp_holds, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind dynamic_partition_allocator_core dpa_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.data[2:0])
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the variable-partition allocator core.
// Depends on dpa_pkg, dpa_if and dynamic_partition_allocator_core.
`timescale 1ns / 1ps
module tb_top;
  localparam int NPART = 32;
  localparam int SETTLE_CYCLES = 140;  // longer than one compaction pass
  localparam int STALL_LIMIT = 4000;
  localparam int QUIET_FROM = 4000;
  localparam int QUIET_TO = 9000;

  typedef struct {
    bit          is_cfg;
    logic        cfg_idx;
    logic [31:0] wdata;
    logic [1:0]  rtype;
    logic [31:0] rsize;
    logic [15:0] fid;
  } word_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] gid;
    logic [31:0] gstart;
  } grant_t;

  logic clk;
  logic rst;

  dpa_if #(.W(50)) req_if ();
  dpa_if #(.W(51)) rsp_if ();
  dpa_if #(.W(33)) cfg_if ();

  dynamic_partition_allocator_core i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source),
    .cfg(cfg_if.sink)
  );

  word_t  pending[$];
  grant_t grants_due[$];
  int     errors = 0;
  int     cyc = 0;
  int     settle = 0;
  int     idle_cycles = 0;

  // Shadow copy of the partition table and its registers.
  logic [1:0]  sh_fit;
  logic [31:0] sh_mem;
  logic [31:0] sh_start[NPART];
  logic [31:0] sh_size[NPART];
  bit          sh_used[NPART];
  logic [15:0] sh_owner[NPART];
  int          sh_count;
  int          sh_next_id;
  int          sh_rover;

  function automatic logic [31:0] managed_bytes();
    return (sh_mem == 0) ? dpa_pkg::DEFAULT_MEMORY : sh_mem;
  endfunction

  function automatic bit is_candidate(int i, logic [31:0] want);
    return !sh_used[i] && sh_size[i] >= want;
  endfunction

  task automatic table_reform();
    for (int i = 0; i < NPART; i++) begin
      sh_start[i] = 0; sh_size[i] = 0; sh_used[i] = 0; sh_owner[i] = 0;
    end
    sh_size[0] = managed_bytes();
    sh_count = 1;
    sh_next_id = 1;
    sh_rover = 0;
  endtask

  // Drop entry j, already merged into j-1; keep the rover on its partition.
  task automatic drop_entry(int j);
    for (int k = j; k + 1 < sh_count; k++) begin
      sh_start[k] = sh_start[k+1]; sh_size[k] = sh_size[k+1];
      sh_used[k] = sh_used[k+1]; sh_owner[k] = sh_owner[k+1];
    end
    sh_count--;
    if (sh_rover >= j && sh_rover > 0) sh_rover--;
  endtask

  function automatic int pick_partition(logic [31:0] want);
    int pick;
    int s;
    pick = -1;
    case (sh_fit)
      dpa_pkg::FIT_FIRST: begin
        for (int i = 0; i < sh_count; i++) if (is_candidate(i, want)) return i;
      end
      dpa_pkg::FIT_BEST: begin
        for (int i = 0; i < sh_count; i++)
          if (is_candidate(i, want) && (pick < 0 || sh_size[i] < sh_size[pick]))
            pick = i;
      end
      dpa_pkg::FIT_WORST: begin
        for (int i = 0; i < sh_count; i++)
          if (is_candidate(i, want) && (pick < 0 || sh_size[i] > sh_size[pick]))
            pick = i;
      end
      default: begin
        s = (sh_rover < sh_count) ? sh_rover : 0;
        for (int i = s; i < sh_count; i++) if (is_candidate(i, want)) return i;
        for (int i = 0; i < s; i++) if (is_candidate(i, want)) return i;
      end
    endcase
    return pick;
  endfunction

  task automatic carve(logic [31:0] want, inout grant_t g);
    int f;
    f = pick_partition(want);
    if (want == 0) begin
      g.status = dpa_pkg::ST_BAD_SIZE;
    end else if (f < 0) begin
      g.status = dpa_pkg::ST_NO_FIT;
    end else if (sh_next_id > 65535) begin
      g.status = dpa_pkg::ST_FULL;
    end else if (sh_size[f] != want && sh_count >= NPART) begin
      g.status = dpa_pkg::ST_FULL;
    end else begin
      if (sh_size[f] != want) begin
        for (int k = sh_count; k > f + 1; k--) begin
          sh_start[k] = sh_start[k-1]; sh_size[k] = sh_size[k-1];
          sh_used[k] = sh_used[k-1]; sh_owner[k] = sh_owner[k-1];
        end
        sh_start[f+1] = sh_start[f] + want;
        sh_size[f+1] = sh_size[f] - want;
        sh_used[f+1] = 0;
        sh_owner[f+1] = 0;
        sh_count++;
        if (sh_rover > f) sh_rover++;
        sh_size[f] = want;
      end
      sh_used[f] = 1;
      sh_owner[f] = sh_next_id[15:0];
      if (sh_fit == dpa_pkg::FIT_NEXT) sh_rover = f;
      g.gid = sh_next_id[15:0];
      g.gstart = sh_start[f];
      sh_next_id++;
    end
  endtask

  task automatic release_id(logic [15:0] id, inout grant_t g);
    int i;
    i = 0;
    if (id == 0) begin
      g.status = dpa_pkg::ST_BAD_ID;
      return;
    end
    while (i < sh_count && !(sh_used[i] && sh_owner[i] == id)) i++;
    if (i >= sh_count) begin
      g.status = dpa_pkg::ST_NOT_FOUND;
      return;
    end
    sh_used[i] = 0;
    sh_owner[i] = 0;
    if (i + 1 < sh_count && !sh_used[i+1]) begin
      sh_size[i] = sh_size[i] + sh_size[i+1];
      drop_entry(i + 1);
    end
    if (i > 0 && !sh_used[i-1]) begin
      sh_size[i-1] = sh_size[i-1] + sh_size[i];
      drop_entry(i);
    end
  endtask

  task automatic squeeze();
    int n;
    longint unsigned curr;
    longint unsigned total;
    n = 0;
    curr = 0;
    total = managed_bytes();
    for (int i = 0; i < sh_count; i++) begin
      if (sh_used[i]) begin
        sh_size[n] = sh_size[i]; sh_owner[n] = sh_owner[i]; sh_used[n] = 1;
        sh_start[n] = curr[31:0];
        curr += sh_size[i];
        n++;
      end
    end
    // No tail partition once the used bytes fill the memory or all NPART entries.
    if (curr < total && n < NPART) begin
      sh_start[n] = curr[31:0];
      sh_size[n] = 32'(total - curr);
      sh_used[n] = 0;
      sh_owner[n] = 0;
      n++;
    end
    for (int i = n; i < NPART; i++) begin
      sh_start[i] = 0; sh_size[i] = 0; sh_used[i] = 0; sh_owner[i] = 0;
    end
    sh_count = n;
    sh_rover = 0;
  endtask

  // Work out the response to one accepted request and queue it.
  task automatic predict_grant(word_t w);
    grant_t g;
    g = '{dpa_pkg::ST_OK, 16'd0, 32'd0};
    case (w.rtype)
      dpa_pkg::REQ_INIT:  table_reform();
      dpa_pkg::REQ_ALLOC: carve(w.rsize, g);
      dpa_pkg::REQ_FREE:  release_id(w.fid, g);
      default:            squeeze();
    endcase
    if (g.status != dpa_pkg::ST_OK) begin
      g.gid = 0;
      g.gstart = 0;
    end
    grants_due.push_back(g);
  endtask

  // Stimulus generation: tracks the ids it expects to hand out.
  int gen_next_id;
  logic [31:0] gen_mem;

  task automatic add_req(logic [1:0] t, logic [31:0] s, logic [15:0] f);
    pending.push_back('{0, 1'b0, 32'd0, t, s, f});
    if (t == dpa_pkg::REQ_ALLOC && s != 0) gen_next_id++;
    if (t == dpa_pkg::REQ_INIT) gen_next_id = 1;
  endtask

  task automatic add_cfg(logic idx, logic [31:0] d);
    pending.push_back('{1, idx, d, dpa_pkg::REQ_INIT, 32'd0, 16'd0});
    if (idx == dpa_pkg::CFG_MEMORY_SIZE) gen_mem = (d == 0) ? dpa_pkg::DEFAULT_MEMORY : d;
  endtask

  task automatic add_random(int n);
    int r;
    logic [31:0] sz;
    logic [15:0] id;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 52) begin
        r = $urandom_range(99);
        if (r < 65)      sz = $urandom_range(1, (gen_mem > 16) ? gen_mem / 16 : 1);
        else if (r < 78) sz = $urandom_range(1, gen_mem);
        else if (r < 88) sz = $urandom;
        else if (r < 94) sz = 0;
        else             sz = gen_mem;
        add_req(dpa_pkg::REQ_ALLOC, sz, 16'($urandom));
      end else if (r < 88) begin
        r = $urandom_range(99);
        if (r < 78)
          id = 16'($urandom_range(1, (gen_next_id > 1) ? gen_next_id - 1 : 1));
        else if (r < 94) id = 16'($urandom);
        else             id = 0;
        add_req(dpa_pkg::REQ_FREE, $urandom, id);
      end else if (r < 97) begin
        add_req(dpa_pkg::REQ_COMPACT, $urandom, 16'($urandom));
      end else begin
        add_req(dpa_pkg::REQ_INIT, $urandom, 16'($urandom));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: present queued words, write registers only when the core is idle.
  always @(posedge clk) begin : drv
    bit nxt_req;
    bit nxt_cfg;
    if (rst) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      cfg_if.valid <= 1'b0;
      cfg_if.data <= '0;
      settle <= 0;
    end else begin
      nxt_req = req_if.valid;
      nxt_cfg = cfg_if.valid;
      if (req_if.valid && req_if.ready) begin
        predict_grant(pending[0]);
        void'(pending.pop_front());
        nxt_req = 0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        if (pending[0].cfg_idx == dpa_pkg::CFG_FIT_MODE) sh_fit = pending[0].wdata[1:0];
        else sh_mem = pending[0].wdata;
        void'(pending.pop_front());
        nxt_cfg = 0;
      end
      if (!nxt_req && !nxt_cfg && pending.size() > 0) begin
        if (pending[0].is_cfg) begin
          // Hold the write until every response is back and the core has settled.
          if (grants_due.size() == 0 && settle >= SETTLE_CYCLES) begin
            nxt_cfg = 1;
            cfg_if.data <= {pending[0].cfg_idx, pending[0].wdata};
          end
        end else if ((cyc >= QUIET_FROM && cyc < QUIET_TO) || $urandom_range(99) >= 8) begin
          nxt_req = 1;
          req_if.data <= {pending[0].fid, pending[0].rsize, pending[0].rtype};
        end
      end
      req_if.valid <= nxt_req;
      cfg_if.valid <= nxt_cfg;
      settle <= (grants_due.size() == 0 && !nxt_req && !req_if.valid) ? settle + 1 : 0;
    end
  end

  // Monitor: compare each response word with the oldest prediction.
  always @(posedge clk) begin : mon
    grant_t g;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (rsp_if.valid && rsp_if.ready) begin
        if (grants_due.size() == 0) begin
          $error("response word with no request outstanding: %h", rsp_if.data);
          errors++;
        end else begin
          g = grants_due.pop_front();
          if (rsp_if.data[2:0] !== g.status) begin
            $error("status: expected %0d, got %0d", g.status, rsp_if.data[2:0]);
            errors++;
          end
          if (rsp_if.data[18:3] !== g.gid) begin
            $error("granted_id: expected %0d, got %0d", g.gid, rsp_if.data[18:3]);
            errors++;
          end
          if (rsp_if.data[50:19] !== g.gstart) begin
            $error("granted_start: expected %h, got %h", g.gstart, rsp_if.data[50:19]);
            errors++;
          end
        end
      end
      rsp_if.ready <= (cyc >= QUIET_FROM && cyc < QUIET_TO) || $urandom_range(99) >= 8;
    end
  end

  // Watchdog: give up when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sh_fit = dpa_pkg::FIT_FIRST;
    sh_mem = dpa_pkg::DEFAULT_MEMORY;
    table_reform();
    gen_next_id = 1;
    gen_mem = dpa_pkg::DEFAULT_MEMORY;
    rst = 1'b1;

    // Directed part at reset settings: status codes, merges, compaction.
    add_req(dpa_pkg::REQ_ALLOC, 32'd0, 16'hFFFF);
    add_req(dpa_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 16'd0);
    add_req(dpa_pkg::REQ_ALLOC, 32'd100, 16'd0);
    add_req(dpa_pkg::REQ_ALLOC, 32'd200, 16'd0);
    add_req(dpa_pkg::REQ_ALLOC, 32'd300, 16'd0);
    add_req(dpa_pkg::REQ_FREE, 32'd0, 16'd0);
    add_req(dpa_pkg::REQ_FREE, 32'd0, 16'hFFFF);
    add_req(dpa_pkg::REQ_FREE, 32'd0, 16'd2);
    add_req(dpa_pkg::REQ_FREE, 32'd0, 16'd2);
    add_req(dpa_pkg::REQ_COMPACT, 32'd0, 16'd0);
    add_req(dpa_pkg::REQ_FREE, 32'd0, 16'd1);
    add_req(dpa_pkg::REQ_FREE, 32'd0, 16'd3);
    add_req(dpa_pkg::REQ_ALLOC, dpa_pkg::DEFAULT_MEMORY, 16'd0);
    add_req(dpa_pkg::REQ_COMPACT, 32'd0, 16'd0);
    add_req(dpa_pkg::REQ_INIT, 32'hFFFF_FFFF, 16'hFFFF);
    // Fill the table; its last split is refused, then a 1 MiB alloc finds no fit.
    for (int k = 0; k < 32; k++) add_req(dpa_pkg::REQ_ALLOC, 32'd1, 16'd0);
    add_req(dpa_pkg::REQ_ALLOC, 32'd1 << 20, 16'd0);
    add_req(dpa_pkg::REQ_FREE, 32'd0, 16'd5);
    add_req(dpa_pkg::REQ_COMPACT, 32'd0, 16'd0);

    // Random phases across every fit and the memory size extremes.
    add_cfg(dpa_pkg::CFG_FIT_MODE, 32'(dpa_pkg::FIT_BEST));
    add_cfg(dpa_pkg::CFG_MEMORY_SIZE, 32'd4096);
    add_req(dpa_pkg::REQ_INIT, 32'd0, 16'd0);
    add_random(45);
    add_cfg(dpa_pkg::CFG_FIT_MODE, 32'(dpa_pkg::FIT_WORST));
    add_cfg(dpa_pkg::CFG_MEMORY_SIZE, 32'hFFFF_FFFF);
    add_req(dpa_pkg::REQ_INIT, 32'd0, 16'd0);
    add_random(45);
    add_cfg(dpa_pkg::CFG_FIT_MODE, 32'(dpa_pkg::FIT_NEXT));
    add_cfg(dpa_pkg::CFG_MEMORY_SIZE, 32'd1);
    add_req(dpa_pkg::REQ_INIT, 32'd0, 16'd0);
    add_random(30);
    add_cfg(dpa_pkg::CFG_MEMORY_SIZE, 32'd0);
    add_req(dpa_pkg::REQ_COMPACT, 32'd0, 16'd0);
    add_random(50);
    add_cfg(dpa_pkg::CFG_FIT_MODE, 32'(dpa_pkg::FIT_FIRST));
    add_cfg(dpa_pkg::CFG_MEMORY_SIZE, 32'd100000);
    add_req(dpa_pkg::REQ_INIT, 32'd0, 16'd0);
    add_random(50);
    add_cfg(dpa_pkg::CFG_FIT_MODE, 32'(dpa_pkg::FIT_NEXT));
    add_cfg(dpa_pkg::CFG_MEMORY_SIZE, 32'd64);
    add_req(dpa_pkg::REQ_INIT, 32'd0, 16'd0);
    add_random(50);
    add_cfg(dpa_pkg::CFG_FIT_MODE, 32'(dpa_pkg::FIT_BEST));
    add_cfg(dpa_pkg::CFG_MEMORY_SIZE, 32'h8000_0000);
    add_req(dpa_pkg::REQ_INIT, 32'd0, 16'd0);
    add_random(45);
    add_cfg(dpa_pkg::CFG_FIT_MODE, 32'(dpa_pkg::FIT_WORST));
    add_cfg(dpa_pkg::CFG_MEMORY_SIZE, dpa_pkg::DEFAULT_MEMORY);
    add_req(dpa_pkg::REQ_INIT, 32'd0, 16'd0);
    add_random(45);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Drain: all words sent, all responses back, then let the core settle.
    while (pending.size() != 0 || grants_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0 && grants_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
